// File: design/vcu_pkg.sv
// Package for the vector clock unit: size constants, operation codes and the
// decoded operation record passed from the front end to the execute stage.
// No dependencies.
package vcu_pkg;

  localparam int THREADS = 8;
  localparam int IDX_W   = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int FUNC_W  = 3;
  localparam int TIDX_W  = 8;
  localparam int VAL_W   = 32;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_JOIN    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_COMPARE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;

  localparam logic [TIDX_W-1:0] THREADS_LIMIT = TIDX_W'(THREADS);

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic                    known;    // func is one of the defined codes
    logic                    ok;       // index within the clock
    logic                    writes;   // add, set or join: entry is updated
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } op_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] entry_value;
    logic                    happens_before;
    logic                    compare_done;
    logic                    index_error;
  } result_t;

endpackage

// File: design/vcu_if.sv
// Valid/ready channel interfaces for the vector clock unit: one for operation
// transactions, one for result transactions. Depends on vcu_pkg.
interface vcu_in_if;
  logic                              valid;
  logic                              ready;
  logic [vcu_pkg::FUNC_W-1:0]        func;
  logic [vcu_pkg::TIDX_W-1:0]        thread_index;
  logic signed [vcu_pkg::VAL_W-1:0]  value;
  logic                              last;

  modport source(output valid, func, thread_index, value, last, input ready);
  modport sink(input valid, func, thread_index, value, last, output ready);
endinterface

interface vcu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vcu_pkg::VAL_W-1:0]  entry_value;
  logic                              happens_before;
  logic                              compare_done;
  logic                              index_error;

  modport source(output valid, entry_value, happens_before, compare_done, index_error,
                 input ready);
  modport sink(input valid, entry_value, happens_before, compare_done, index_error,
               output ready);
endinterface

// File: design/vcu_front.sv
// Front end: accepts operation transactions and classifies them (known code,
// index range, whether the entry is written). Depends on vcu_pkg, vcu_if.
module vcu_front (
  vcu_in_if.sink          in_ch,
  output logic            op_valid,
  input  logic            op_ready,
  output vcu_pkg::op_t    op
);

  assign op_valid    = in_ch.valid;
  assign in_ch.ready = op_ready;

  always_comb begin
    op.func   = in_ch.func;
    op.idx    = in_ch.thread_index[vcu_pkg::IDX_W-1:0];
    op.value  = in_ch.value;
    op.last   = in_ch.last;
    op.ok     = in_ch.thread_index < vcu_pkg::THREADS_LIMIT;
    op.known  = 1'b0;
    op.writes = 1'b0;
    case (in_ch.func)
      vcu_pkg::FUNC_ADD, vcu_pkg::FUNC_SET, vcu_pkg::FUNC_JOIN: begin
        op.known  = 1'b1;
        op.writes = 1'b1;
      end
      vcu_pkg::FUNC_COMPARE, vcu_pkg::FUNC_READ: begin
        op.known = 1'b1;
      end
      default: begin
        op.known = 1'b0;
      end
    endcase
  end

endmodule

// File: design/vcu_queue.sv
// Two-entry queue of decoded operations between the front end and the
// execute stage. Depends on vcu_pkg.
module vcu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  vcu_pkg::op_t  wr_op,
  output logic          rd_valid,
  input  logic          rd_ready,
  output vcu_pkg::op_t  rd_op
);

  vcu_pkg::op_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_op    = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/vcu_back.sv
// Execute stage (needs vcu_pkg, vcu_if): holds clock entries, compare flags;
// runs one operation per cycle unless out_ch stalls, registering the result.
module vcu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  vcu_pkg::op_t  op,
  vcu_out_if.source     out_ch
);

  logic signed [vcu_pkg::VAL_W-1:0] entries [vcu_pkg::THREADS];
  logic                             seen_greater;
  logic                             seen_smaller;
  logic                             out_valid;
  vcu_pkg::result_t                 result;

  logic                             pop;
  logic signed [vcu_pkg::VAL_W-1:0] cur;
  logic signed [vcu_pkg::VAL_W-1:0] entry_next;
  logic                             seen_greater_next;
  logic                             seen_smaller_next;
  vcu_pkg::result_t                 result_next;
  logic                             is_compare;
  logic                             done;

  // advance whenever the output register is free or being drained
  assign op_ready = !out_valid || out_ch.ready;
  assign pop      = op_valid && op_ready;

  assign cur        = entries[op.idx];
  assign is_compare = (op.func == vcu_pkg::FUNC_COMPARE);
  assign done       = is_compare && op.last;

  always_comb begin
    case (op.func)
      vcu_pkg::FUNC_ADD:  entry_next = cur + op.value;
      vcu_pkg::FUNC_SET:  entry_next = op.value;
      vcu_pkg::FUNC_JOIN: entry_next = (op.value > cur) ? op.value : cur;
      default:            entry_next = cur;
    endcase
  end

  always_comb begin
    seen_greater_next = seen_greater;
    seen_smaller_next = seen_smaller;
    if (is_compare && op.ok) begin
      if (cur > op.value) seen_greater_next = 1'b1;
      else if (op.value > cur) seen_smaller_next = 1'b1;
    end

    result_next.entry_value    = (op.known && op.ok) ? entry_next : '0;
    result_next.index_error    = op.known && !op.ok;
    result_next.compare_done   = done;
    result_next.happens_before = done && !seen_greater_next && seen_smaller_next;

    // end of stream: drop the flags for the next compare
    if (done) begin
      seen_greater_next = 1'b0;
      seen_smaller_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vcu_pkg::THREADS; i++) begin
        entries[i] <= '0;
      end
      seen_greater <= 1'b0;
      seen_smaller <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        if (op.ok && op.writes) entries[op.idx] <= entry_next;
        seen_greater <= seen_greater_next;
        seen_smaller <= seen_smaller_next;
        out_valid    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.entry_value    = result.entry_value;
  assign out_ch.happens_before = result.happens_before;
  assign out_ch.compare_done   = result.compare_done;
  assign out_ch.index_error    = result.index_error;

endmodule

// File: design/vector_clock_unit_top.sv
// Vector clock unit top level: front end, operation queue and execute stage.
// Depends on vcu_pkg, vcu_if, vcu_front, vcu_queue, vcu_back.
//
// Usage:
//   in_ch carries one operation transaction (func, thread_index, value, last)
//   on the vector clock of THREADS signed 32-bit entries; out_ch returns
//   exactly one result transaction for each, in order.
//   Compare and join streams send the other clock one element per
//   transaction; the compare verdict appears on the element marked last.
// Timing:
//   An accepted transaction waits in a queue slot; its result is registered
//   in the output register. Throughput is one transaction per cycle unless
//   out_ch stalls; the execute stage's read-modify-write of one entry sets it.
// Reset:
//   rst (synchronous) clears all entries, both compare flags, the queue and
//   the output valid flag; the block accepts input in the next cycle.
// Backpressure:
//   When out_ch stalls, the result holds in the output register, the queue
//   takes up to two more transactions, then in_ch.ready drops.
module vector_clock_unit_top (
  input  logic       clk,
  input  logic       rst,
  vcu_in_if.sink     in_ch,
  vcu_out_if.source  out_ch
);

  logic         front_valid;
  logic         front_ready;
  vcu_pkg::op_t front_op;
  logic         back_valid;
  logic         back_ready;
  vcu_pkg::op_t back_op;

  vcu_front u_front (
    .in_ch    (in_ch),
    .op_valid (front_valid),
    .op_ready (front_ready),
    .op       (front_op)
  );

  vcu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_op    (front_op),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_op    (back_op)
  );

  vcu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (back_valid),
    .op_ready (back_ready),
    .op       (back_op),
    .out_ch   (out_ch)
  );

endmodule
